@@ sv/sttk_pkg.sv @@
`default_nettype none
package sttk_pkg;

  localparam int POS_BITS_DEF = 16;
  localparam int KIND_W       = 6;
  localparam int FIELD_W      = 16;
  localparam int MAX_RES      = 4;
  localparam int CNT_W        = 3;

  // token kinds
  localparam logic [KIND_W-1:0] K_IDENT   = 6'd0;
  localparam logic [KIND_W-1:0] K_INT     = 6'd1;
  localparam logic [KIND_W-1:0] K_FLOAT   = 6'd2;
  localparam logic [KIND_W-1:0] K_STRING  = 6'd3;
  localparam logic [KIND_W-1:0] K_CHAR    = 6'd4;
  localparam logic [KIND_W-1:0] K_UNKNOWN = 6'd5;
  localparam logic [KIND_W-1:0] K_TERM    = 6'd6;
  localparam logic [KIND_W-1:0] K_EOF     = 6'd7;
  localparam logic [KIND_W-1:0] K_RANGE   = 6'd32;
  localparam logic [KIND_W-1:0] NO_KIND   = 6'h3F;

  // special bytes
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;

  // scanner modes
  typedef enum logic [10:0] {
    M_IDLE      = 11'b000_0000_0001,
    M_IDENT     = 11'b000_0000_0010,
    M_NUMBER    = 11'b000_0000_0100,
    M_NUM_DOT   = 11'b000_0000_1000,
    M_FLOAT     = 11'b000_0001_0000,
    M_STRING    = 11'b000_0010_0000,
    M_STRING_BS = 11'b000_0100_0000,
    M_OP        = 11'b000_1000_0000,
    M_OP_PLAIN  = 11'b001_0000_0000,
    M_COMMENT   = 11'b010_0000_0000,
    M_UNKNOWN   = 11'b100_0000_0000
  } mode_t;

  // one token record
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FIELD_W-1:0] line;
    logic [FIELD_W-1:0] col;
    logic [FIELD_W-1:0] off;
    logic [FIELD_W-1:0] len;
    logic               last;
  } rec_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return (c == CH_UNDER) || is_alpha(c) || is_digit(c);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h00) || (c == 8'h0D) || (c == 8'h09);
  endfunction

  // operators that never pair
  function automatic logic [KIND_W-1:0] lone_kind(input logic [7:0] c);
    logic [KIND_W-1:0] k;
    case (c)
      8'h2C:   k = 6'd24;
      8'h7B:   k = 6'd25;
      8'h7D:   k = 6'd26;
      8'h28:   k = 6'd27;
      8'h29:   k = 6'd28;
      8'h5B:   k = 6'd29;
      8'h5D:   k = 6'd30;
      8'h7E:   k = 6'd43;
      8'h24:   k = 6'd44;
      8'h3B:   k = K_TERM;
      8'h40:   k = 6'd45;
      default: k = NO_KIND;
    endcase
    return k;
  endfunction

  // operators that may pair, kind when alone
  function automatic logic [KIND_W-1:0] first_kind(input logic [7:0] c);
    logic [KIND_W-1:0] k;
    case (c)
      8'h3D:   k = 6'd8;
      8'h2B:   k = 6'd11;
      8'h2D:   k = 6'd13;
      8'h2A:   k = 6'd16;
      8'h2F:   k = 6'd18;
      8'h25:   k = 6'd20;
      8'h3A:   k = 6'd22;
      8'h2E:   k = 6'd31;
      8'h21:   k = 6'd33;
      8'h3C:   k = 6'd35;
      8'h3E:   k = 6'd37;
      8'h7C:   k = 6'd39;
      8'h26:   k = 6'd41;
      default: k = NO_KIND;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] pair_kind(input logic [7:0] h, input logic [7:0] c);
    logic [KIND_W-1:0] k;
    case (h)
      8'h3D:   k = (c == 8'h3D) ? 6'd9 : ((c == 8'h3E) ? 6'd10 : NO_KIND);
      8'h2B:   k = (c == 8'h3D) ? 6'd12 : NO_KIND;
      8'h2D:   k = (c == 8'h3E) ? 6'd14 : ((c == 8'h3D) ? 6'd15 : NO_KIND);
      8'h2A:   k = (c == 8'h3D) ? 6'd17 : NO_KIND;
      8'h2F:   k = (c == 8'h3D) ? 6'd19 : NO_KIND;
      8'h25:   k = (c == 8'h3D) ? 6'd21 : NO_KIND;
      8'h3A:   k = (c == 8'h3A) ? 6'd23 : NO_KIND;
      8'h2E:   k = (c == 8'h2E) ? 6'd32 : NO_KIND;
      8'h21:   k = (c == 8'h3D) ? 6'd34 : NO_KIND;
      8'h3C:   k = (c == 8'h3D) ? 6'd36 : NO_KIND;
      8'h3E:   k = (c == 8'h3D) ? 6'd38 : NO_KIND;
      8'h7C:   k = (c == 8'h7C) ? 6'd40 : NO_KIND;
      8'h26:   k = (c == 8'h26) ? 6'd42 : NO_KIND;
      default: k = NO_KIND;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

@@ sv/sttk_lexer.sv @@
`default_nettype none
module sttk_lexer #(
  parameter int POS_BITS = sttk_pkg::POS_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              step,
  input  wire  [7:0]                       ch,
  input  wire                              end_of_source,
  output sttk_pkg::rec_t [sttk_pkg::MAX_RES-1:0] res,
  output logic [sttk_pkg::CNT_W-1:0]       n
);

  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);
  localparam logic [POS_BITS-1:0] POS_TWO = POS_BITS'(2);
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  // scanner state
  sttk_pkg::mode_t    mode, m;
  logic [7:0]         held, hb;
  logic [7:0]         quote, qb;
  logic [POS_BITS-1:0] tstart, ts;
  logic [POS_BITS-1:0] rlen, rl;
  logic [POS_BITS-1:0] pos, p, ps, prev;
  logic [POS_BITS-1:0] lbegin, lb;
  logic [15:0]        lcount, lc;
  logic               do_idle;
  logic [sttk_pkg::KIND_W-1:0] k;

  function automatic logic [POS_BITS-1:0] inc(input logic [POS_BITS-1:0] x);
    return (x == POS_MAX) ? x : x + POS_ONE;
  endfunction

  function automatic logic [15:0] clampw(input logic [POS_BITS:0] x);
    return (x > (POS_BITS+1)'(17'h0FFFF)) ? 16'hFFFF : 16'(x);
  endfunction

  function automatic sttk_pkg::rec_t mk(input logic [sttk_pkg::KIND_W-1:0] kind,
                                        input logic [POS_BITS-1:0] start,
                                        input logic [POS_BITS-1:0] len,
                                        input logic [15:0] line,
                                        input logic [POS_BITS-1:0] lbeg);
    sttk_pkg::rec_t r;
    logic [POS_BITS:0] colw;
    colw = (start >= lbeg) ? ({1'b0, start} - {1'b0, lbeg} + (POS_BITS+1)'(1))
                           : (POS_BITS+1)'(1);
    r.kind = kind;
    r.line = line;
    r.col  = clampw(colw);
    r.off  = clampw({1'b0, start});
    r.len  = clampw({1'b0, len});
    r.last = 1'b0;
    return r;
  endfunction

  // one byte through the scanner
  always_comb begin
    m = mode; hb = held; qb = quote; ts = tstart; rl = rlen;
    lb = lbegin; lc = lcount; p = pos;
    n = '0; res = '0; do_idle = 1'b0;
    prev = (p != '0) ? p - POS_ONE : '0;
    k = sttk_pkg::pair_kind(held, ch);

    case (mode)
      sttk_pkg::M_IDENT: begin
        if (sttk_pkg::is_ident(ch)) rl = inc(rl);
        else begin
          res[n[1:0]] = mk(sttk_pkg::K_IDENT, ts, rl, lc, lb); n = n + 3'd1;
          do_idle = 1'b1;
        end
      end
      sttk_pkg::M_NUMBER: begin
        if (sttk_pkg::is_digit(ch)) rl = inc(rl);
        else if (ch == sttk_pkg::CH_DOT) m = sttk_pkg::M_NUM_DOT;
        else begin
          res[n[1:0]] = mk(sttk_pkg::K_INT, ts, rl, lc, lb); n = n + 3'd1;
          do_idle = 1'b1;
        end
      end
      sttk_pkg::M_NUM_DOT: begin
        if (ch == sttk_pkg::CH_DOT) begin
          res[n[1:0]] = mk(sttk_pkg::K_INT, ts, rl, lc, lb); n = n + 3'd1;
          res[n[1:0]] = mk(sttk_pkg::K_RANGE, prev, POS_TWO, lc, lb); n = n + 3'd1;
          m = sttk_pkg::M_IDLE;
        end else if (sttk_pkg::is_digit(ch)) begin
          rl = inc(inc(rl));
          m = sttk_pkg::M_FLOAT;
        end else begin
          res[n[1:0]] = mk(sttk_pkg::K_UNKNOWN, ts, inc(rl), lc, lb); n = n + 3'd1;
          if (ch == sttk_pkg::CH_SLASH) begin
            m = sttk_pkg::M_OP_PLAIN; hb = ch; ts = p; rl = POS_ONE;
          end else begin
            do_idle = 1'b1;
          end
        end
      end
      sttk_pkg::M_FLOAT: begin
        if (sttk_pkg::is_digit(ch)) rl = inc(rl);
        else begin
          res[n[1:0]] = mk(sttk_pkg::K_FLOAT, ts, rl, lc, lb); n = n + 3'd1;
          do_idle = 1'b1;
        end
      end
      sttk_pkg::M_STRING, sttk_pkg::M_STRING_BS: begin
        if (mode == sttk_pkg::M_STRING_BS && ch == sttk_pkg::CH_LOW_N) begin
          res[n[1:0]] = mk(sttk_pkg::K_UNKNOWN, ts, rl, lc, lb); n = n + 3'd1;
          m = sttk_pkg::M_UNKNOWN; ts = prev; rl = POS_TWO;
        end else begin
          // escaped byte counts the backslash too
          if (mode == sttk_pkg::M_STRING_BS) begin
            rl = inc(rl); m = sttk_pkg::M_STRING;
          end
          if (ch == sttk_pkg::CH_NL) begin
            res[n[1:0]] = mk(sttk_pkg::K_UNKNOWN, ts, rl, lc, lb); n = n + 3'd1;
            do_idle = 1'b1;
          end else if (ch == sttk_pkg::CH_BSLASH) begin
            m = sttk_pkg::M_STRING_BS;
          end else begin
            rl = inc(rl);
            if (ch == qb) begin
              res[n[1:0]] = mk((qb == sttk_pkg::CH_DQUOTE) ? sttk_pkg::K_STRING
                                                            : sttk_pkg::K_CHAR,
                               ts, rl, lc, lb);
              n = n + 3'd1;
              m = sttk_pkg::M_IDLE;
            end
          end
        end
      end
      sttk_pkg::M_OP, sttk_pkg::M_OP_PLAIN: begin
        m = sttk_pkg::M_IDLE;
        if (mode == sttk_pkg::M_OP && held == sttk_pkg::CH_SLASH &&
            ch == sttk_pkg::CH_SLASH) begin
          m = sttk_pkg::M_COMMENT;
        end else if (k != sttk_pkg::NO_KIND) begin
          res[n[1:0]] = mk(k, ts, POS_TWO, lc, lb); n = n + 3'd1;
        end else begin
          res[n[1:0]] = mk(sttk_pkg::first_kind(held), ts, POS_ONE, lc, lb);
          n = n + 3'd1;
          do_idle = 1'b1;
        end
      end
      sttk_pkg::M_COMMENT: begin
        if (ch == sttk_pkg::CH_NL) do_idle = 1'b1;
      end
      sttk_pkg::M_UNKNOWN: begin
        if (sttk_pkg::is_space(ch) || ch == sttk_pkg::CH_NL) begin
          res[n[1:0]] = mk(sttk_pkg::K_UNKNOWN, ts, rl, lc, lb); n = n + 3'd1;
          do_idle = 1'b1;
        end else begin
          rl = inc(rl);
        end
      end
      default: do_idle = 1'b1;
    endcase

    // byte seen from idle
    if (do_idle) begin
      m = sttk_pkg::M_IDLE;
      if (ch == sttk_pkg::CH_NL) begin
        res[n[1:0]] = mk(sttk_pkg::K_TERM, p, POS_ONE, lc, lb); n = n + 3'd1;
        if (lc != 16'hFFFF) lc = lc + 16'd1;
        lb = inc(p);
      end else if (sttk_pkg::is_space(ch)) begin
        m = sttk_pkg::M_IDLE;
      end else if (sttk_pkg::is_digit(ch)) begin
        m = sttk_pkg::M_NUMBER; ts = p; rl = POS_ONE;
      end else if (ch == sttk_pkg::CH_UNDER || sttk_pkg::is_alpha(ch)) begin
        m = sttk_pkg::M_IDENT; ts = p; rl = POS_ONE;
      end else if (ch == sttk_pkg::CH_DQUOTE || ch == sttk_pkg::CH_SQUOTE) begin
        m = sttk_pkg::M_STRING; ts = p; rl = POS_ONE; qb = ch;
      end else if (sttk_pkg::lone_kind(ch) != sttk_pkg::NO_KIND) begin
        res[n[1:0]] = mk(sttk_pkg::lone_kind(ch), p, POS_ONE, lc, lb); n = n + 3'd1;
      end else if (sttk_pkg::first_kind(ch) != sttk_pkg::NO_KIND) begin
        m = sttk_pkg::M_OP; hb = ch; ts = p; rl = POS_ONE;
      end else begin
        m = sttk_pkg::M_UNKNOWN; ts = p; rl = POS_ONE;
      end
    end

    ps = inc(p);

    // end of source: flush, close line, eof
    if (end_of_source) begin
      case (m)
        sttk_pkg::M_STRING: begin
          res[n[1:0]] = mk(sttk_pkg::K_UNKNOWN, ts, rl, lc, lb); n = n + 3'd1;
        end
        sttk_pkg::M_STRING_BS, sttk_pkg::M_NUM_DOT: begin
          res[n[1:0]] = mk(sttk_pkg::K_UNKNOWN, ts, inc(rl), lc, lb); n = n + 3'd1;
        end
        sttk_pkg::M_IDENT: begin
          res[n[1:0]] = mk(sttk_pkg::K_IDENT, ts, rl, lc, lb); n = n + 3'd1;
        end
        sttk_pkg::M_NUMBER: begin
          res[n[1:0]] = mk(sttk_pkg::K_INT, ts, rl, lc, lb); n = n + 3'd1;
        end
        sttk_pkg::M_FLOAT: begin
          res[n[1:0]] = mk(sttk_pkg::K_FLOAT, ts, rl, lc, lb); n = n + 3'd1;
        end
        sttk_pkg::M_OP, sttk_pkg::M_OP_PLAIN: begin
          res[n[1:0]] = mk(sttk_pkg::first_kind(hb), ts, POS_ONE, lc, lb);
          n = n + 3'd1;
        end
        sttk_pkg::M_UNKNOWN: begin
          res[n[1:0]] = mk(sttk_pkg::K_UNKNOWN, ts, rl, lc, lb); n = n + 3'd1;
        end
        default: n = n;
      endcase
      if (ch != sttk_pkg::CH_NL) begin
        if (n < 3'(sttk_pkg::MAX_RES)) begin
          res[n[1:0]] = mk(sttk_pkg::K_TERM, ps, POS_ONE, lc, lb); n = n + 3'd1;
        end
        if (lc != 16'hFFFF) lc = lc + 16'd1;
        ps = inc(ps);
      end
      if (n < 3'(sttk_pkg::MAX_RES)) begin
        res[n[1:0]] = mk(sttk_pkg::K_EOF, ps, '0, lc, lb);
        res[n[1:0]].col = '0;
        n = n + 3'd1;
      end
      m = sttk_pkg::M_IDLE; hb = '0; qb = '0; ts = '0; rl = '0;
      ps = '0; lb = '0; lc = 16'd1;
    end

    if (n != '0) res[n[1:0] - 2'd1].last = 1'b1;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= sttk_pkg::M_IDLE;
      held   <= '0;
      quote  <= '0;
      tstart <= '0;
      rlen   <= '0;
      pos    <= '0;
      lbegin <= '0;
      lcount <= 16'd1;
    end else if (step) begin
      mode   <= m;
      held   <= hb;
      quote  <= qb;
      tstart <= ts;
      rlen   <= rl;
      pos    <= ps;
      lbegin <= lb;
      lcount <= lc;
    end
  end

endmodule
`default_nettype wire

@@ sv/sttk_outbuf.sv @@
`default_nettype none
module sttk_outbuf (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    load,
  input  sttk_pkg::rec_t [sttk_pkg::MAX_RES-1:0] load_recs,
  input  wire  [sttk_pkg::CNT_W-1:0]             load_cnt,
  input  wire                                    take,
  output logic                                   can_load,
  output logic                                   valid,
  output sttk_pkg::rec_t                         rec
);

  sttk_pkg::rec_t [sttk_pkg::MAX_RES-1:0] recs;
  logic [sttk_pkg::CNT_W-1:0] cnt;
  logic [sttk_pkg::CNT_W-1:0] idx;

  // drain one record a cycle while take is high
  assign valid    = idx < cnt;
  assign rec      = recs[idx[1:0]];
  assign can_load = !valid || ((idx + 3'd1 == cnt) && take);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (load) begin
      cnt <= load_cnt;
      idx <= '0;
    end else if (valid && take) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      recs <= load_recs;
    end
  end

endmodule
`default_nettype wire

@@ sv/source_tokenizer.sv @@
`default_nettype none
// Streaming tokenizer: one source byte per src transaction, zero to four token
// records per byte on the tok channel, one record per tok transaction, with
// final_of_run marking the last record of a byte. The records of a byte appear
// the cycle after the byte is taken. A byte is taken every cycle as long as each
// byte gives at most one record and tok_ready stays high. A byte that gives more
// than one record holds the source side while the four-entry record buffer drains.
// In the cycle the last record leaves, src_ready follows tok_ready.
// Raise end_of_source on the last byte: open tokens are flushed, the line is
// closed, an eof record follows, and the scanner starts over for the next source.
module source_tokenizer #(
  parameter int POS_BITS = sttk_pkg::POS_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         src_valid,
  output logic        src_ready,
  input  wire  [7:0]  ch,
  input  wire         end_of_source,
  output logic        tok_valid,
  input  wire         tok_ready,
  output logic [5:0]  token_kind,
  output logic [15:0] line_no,
  output logic [15:0] column_no,
  output logic [15:0] byte_offset,
  output logic [15:0] token_len,
  output logic        final_of_run
);

  sttk_pkg::rec_t [sttk_pkg::MAX_RES-1:0] recs;
  sttk_pkg::rec_t rec;
  logic [sttk_pkg::CNT_W-1:0] cnt;
  logic step;

  assign step = src_valid && src_ready;

  // scanner
  sttk_lexer #(.POS_BITS(POS_BITS)) u_lexer (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .ch            (ch),
    .end_of_source (end_of_source),
    .res           (recs),
    .n             (cnt)
  );

  // record buffer
  sttk_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .load_recs (recs),
    .load_cnt  (cnt),
    .take      (tok_ready),
    .can_load  (src_ready),
    .valid     (tok_valid),
    .rec       (rec)
  );

  assign token_kind   = rec.kind;
  assign line_no      = rec.line;
  assign column_no    = rec.col;
  assign byte_offset  = rec.off;
  assign token_len    = rec.len;
  assign final_of_run = rec.last;

endmodule
`default_nettype wire

@@ tb/source_tokenizer_checker.sv @@
`timescale 1ns / 100ps
`default_nettype none
module source_tokenizer_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire         src_valid,
  input  wire         src_ready,
  input  wire  [7:0]  ch,
  input  wire         end_of_source,
  input  wire         tok_valid,
  input  wire         tok_ready,
  input  wire  [5:0]  token_kind,
  input  wire  [15:0] line_no,
  input  wire  [15:0] column_no,
  input  wire  [15:0] byte_offset,
  input  wire  [15:0] token_len,
  input  wire         final_of_run,
  output int          errors,
  output int          tokens_pending,
  output int          bytes_seen,
  output int          tokens_seen
);

  // dense token classes
  typedef enum logic [5:0] {
    TK_IDENT, TK_INT, TK_FLOAT, TK_STRING, TK_CHAR, TK_UNKNOWN, TK_TERM, TK_EOF,
    TK_ASSIGN, TK_EQ, TK_FAT_ARROW, TK_PLUS, TK_PLUS_EQ, TK_MINUS, TK_ARROW,
    TK_MINUS_EQ, TK_STAR, TK_STAR_EQ, TK_SLASH, TK_SLASH_EQ, TK_PCT, TK_PCT_EQ,
    TK_COLON, TK_SCOPE, TK_COMMA, TK_LBRACE, TK_RBRACE, TK_LPAREN, TK_RPAREN,
    TK_LBRACK, TK_RBRACK, TK_DOT, TK_RANGE, TK_BANG, TK_NE, TK_LT, TK_LE, TK_GT,
    TK_GE, TK_BAR, TK_OR, TK_AMP, TK_AND, TK_TILDE, TK_DOLLAR, TK_AT,
    TK_NONE = 6'h3F
  } tok_kind_t;

  localparam int POS_MAX = (1 << sttk_pkg::POS_BITS_DEF) - 1;

  // scanner copy
  sttk_pkg::mode_t scan;
  logic [7:0] op_byte;
  logic [7:0] quote;
  int     tok_start, run_len, pos, line_base, line_cnt;
  sttk_pkg::rec_t byte_toks[$];
  sttk_pkg::rec_t tokens_due[$];

  function automatic int sat_inc(input int x);
    return x < POS_MAX ? x + 1 : POS_MAX;
  endfunction

  function automatic logic [15:0] clip(input int x);
    return x > 65535 ? 16'hFFFF : x[15:0];
  endfunction

  function automatic logic digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == sttk_pkg::CH_UNDER;
  endfunction

  function automatic logic blank(input logic [7:0] c);
    return c == " " || c == 8'h00 || c == 8'h0D || c == 8'h09;
  endfunction

  function automatic tok_kind_t single_op(input logic [7:0] c);
    case (c)
      ",": return TK_COMMA;
      "{": return TK_LBRACE;
      "}": return TK_RBRACE;
      "(": return TK_LPAREN;
      ")": return TK_RPAREN;
      "[": return TK_LBRACK;
      "]": return TK_RBRACK;
      "~": return TK_TILDE;
      "$": return TK_DOLLAR;
      ";": return TK_TERM;
      "@": return TK_AT;
      default: return TK_NONE;
    endcase
  endfunction

  function automatic tok_kind_t lead_op(input logic [7:0] c);
    case (c)
      "=": return TK_ASSIGN;
      "+": return TK_PLUS;
      "-": return TK_MINUS;
      "*": return TK_STAR;
      "/": return TK_SLASH;
      "%": return TK_PCT;
      ":": return TK_COLON;
      ".": return TK_DOT;
      "!": return TK_BANG;
      "<": return TK_LT;
      ">": return TK_GT;
      "|": return TK_BAR;
      "&": return TK_AMP;
      default: return TK_NONE;
    endcase
  endfunction

  function automatic tok_kind_t joined_op(input logic [7:0] h, input logic [7:0] c);
    if (c == "=") begin
      case (h)
        "=": return TK_EQ;
        "+": return TK_PLUS_EQ;
        "-": return TK_MINUS_EQ;
        "*": return TK_STAR_EQ;
        "/": return TK_SLASH_EQ;
        "%": return TK_PCT_EQ;
        "!": return TK_NE;
        "<": return TK_LE;
        ">": return TK_GE;
        default: return TK_NONE;
      endcase
    end
    if (c == ">" && h == "=") return TK_FAT_ARROW;
    if (c == ">" && h == "-") return TK_ARROW;
    if (c == h) begin
      case (h)
        ":": return TK_SCOPE;
        ".": return TK_RANGE;
        "|": return TK_OR;
        "&": return TK_AND;
        default: return TK_NONE;
      endcase
    end
    return TK_NONE;
  endfunction

  task automatic put_tok(input tok_kind_t k, input int ln, input int col, input int off,
                         input int len);
    sttk_pkg::rec_t r;
    if (byte_toks.size() < sttk_pkg::MAX_RES) begin
      r.kind = k;
      r.line = clip(ln);
      r.col  = clip(col);
      r.off  = clip(off);
      r.len  = clip(len);
      r.last = 1'b0;
      byte_toks = {byte_toks, r};
    end
  endtask

  task automatic emit(input tok_kind_t k, input int start, input int len);
    put_tok(k, line_cnt, start >= line_base ? start - line_base + 1 : 1, start, len);
  endtask

  task automatic open_tok(input sttk_pkg::mode_t m, input int p);
    scan = m;
    tok_start = p;
    run_len = 1;
  endtask

  task automatic hold(input sttk_pkg::mode_t m, input logic [7:0] c, input int p);
    open_tok(m, p);
    op_byte = c;
  endtask

  task automatic scanner_reset();
    scan = sttk_pkg::M_IDLE;
    op_byte = 8'h00;
    quote = 8'h00;
    tok_start = 0;
    run_len = 0;
    pos = 0;
    line_base = 0;
    line_cnt = 1;
  endtask

  // byte seen with no token open
  task automatic fresh_byte(input logic [7:0] c, input int p);
    scan = sttk_pkg::M_IDLE;
    if (c == sttk_pkg::CH_NL) begin
      emit(TK_TERM, p, 1);
      if (line_cnt < 65535) line_cnt++;
      line_base = sat_inc(p);
    end else if (blank(c)) begin
    end else if (digit(c)) begin
      open_tok(sttk_pkg::M_NUMBER, p);
    end else if (letter(c)) begin
      open_tok(sttk_pkg::M_IDENT, p);
    end else if (c == sttk_pkg::CH_DQUOTE || c == sttk_pkg::CH_SQUOTE) begin
      open_tok(sttk_pkg::M_STRING, p);
      quote = c;
    end else if (single_op(c) != TK_NONE) begin
      emit(single_op(c), p, 1);
    end else if (lead_op(c) != TK_NONE) begin
      hold(sttk_pkg::M_OP, c, p);
    end else begin
      open_tok(sttk_pkg::M_UNKNOWN, p);
    end
  endtask

  task automatic quoted_byte(input logic [7:0] c, input int p);
    if (c == sttk_pkg::CH_NL) begin
      emit(TK_UNKNOWN, tok_start, run_len);
      fresh_byte(c, p);
    end else if (c == sttk_pkg::CH_BSLASH) begin
      scan = sttk_pkg::M_STRING_BS;
    end else begin
      run_len = sat_inc(run_len);
      if (c == quote) begin
        emit(quote == sttk_pkg::CH_DQUOTE ? TK_STRING : TK_CHAR, tok_start, run_len);
        scan = sttk_pkg::M_IDLE;
      end
    end
  endtask

  task automatic scan_byte(input logic [7:0] c, input int p);
    int prev;
    tok_kind_t k;
    logic [7:0] h;
    prev = p > 0 ? p - 1 : 0;
    case (scan)
      sttk_pkg::M_IDENT: begin
        if (letter(c) || digit(c)) run_len = sat_inc(run_len);
        else begin
          emit(TK_IDENT, tok_start, run_len);
          fresh_byte(c, p);
        end
      end
      sttk_pkg::M_NUMBER: begin
        if (digit(c)) run_len = sat_inc(run_len);
        else if (c == sttk_pkg::CH_DOT) scan = sttk_pkg::M_NUM_DOT;
        else begin
          emit(TK_INT, tok_start, run_len);
          fresh_byte(c, p);
        end
      end
      sttk_pkg::M_NUM_DOT: begin
        if (c == sttk_pkg::CH_DOT) begin
          emit(TK_INT, tok_start, run_len);
          emit(TK_RANGE, prev, 2);
          scan = sttk_pkg::M_IDLE;
        end else if (digit(c)) begin
          run_len = sat_inc(sat_inc(run_len));
          scan = sttk_pkg::M_FLOAT;
        end else begin
          // incomplete float, a slash after it never opens a comment
          emit(TK_UNKNOWN, tok_start, sat_inc(run_len));
          if (c == sttk_pkg::CH_SLASH) hold(sttk_pkg::M_OP_PLAIN, c, p);
          else fresh_byte(c, p);
        end
      end
      sttk_pkg::M_FLOAT: begin
        if (digit(c)) run_len = sat_inc(run_len);
        else begin
          emit(TK_FLOAT, tok_start, run_len);
          fresh_byte(c, p);
        end
      end
      sttk_pkg::M_STRING: quoted_byte(c, p);
      sttk_pkg::M_STRING_BS: begin
        if (c == sttk_pkg::CH_LOW_N) begin
          emit(TK_UNKNOWN, tok_start, run_len);
          scan = sttk_pkg::M_UNKNOWN;
          tok_start = prev;
          run_len = 2;
        end else begin
          run_len = sat_inc(run_len);
          scan = sttk_pkg::M_STRING;
          quoted_byte(c, p);
        end
      end
      sttk_pkg::M_OP, sttk_pkg::M_OP_PLAIN: begin
        h = op_byte;
        k = joined_op(h, c);
        if (scan == sttk_pkg::M_OP && h == sttk_pkg::CH_SLASH && c == sttk_pkg::CH_SLASH) begin
          scan = sttk_pkg::M_COMMENT;
        end else if (k != TK_NONE) begin
          scan = sttk_pkg::M_IDLE;
          emit(k, tok_start, 2);
        end else begin
          scan = sttk_pkg::M_IDLE;
          emit(lead_op(h), tok_start, 1);
          fresh_byte(c, p);
        end
      end
      sttk_pkg::M_COMMENT: begin
        if (c == sttk_pkg::CH_NL) fresh_byte(c, p);
      end
      sttk_pkg::M_UNKNOWN: begin
        if (blank(c) || c == sttk_pkg::CH_NL) begin
          emit(TK_UNKNOWN, tok_start, run_len);
          fresh_byte(c, p);
        end else begin
          run_len = sat_inc(run_len);
        end
      end
      default: fresh_byte(c, p);
    endcase
  endtask

  // tokens caused by one source byte
  task automatic tokenize_byte(input logic [7:0] c, input logic last);
    byte_toks.delete();
    scan_byte(c, pos);
    pos = sat_inc(pos);
    if (last) begin
      if (scan == sttk_pkg::M_STRING) emit(TK_UNKNOWN, tok_start, run_len);
      else if (scan == sttk_pkg::M_STRING_BS) emit(TK_UNKNOWN, tok_start, sat_inc(run_len));
      else if (scan != sttk_pkg::M_COMMENT && scan != sttk_pkg::M_IDLE) scan_byte(8'h00, pos);
      if (c != sttk_pkg::CH_NL) begin
        emit(TK_TERM, pos, 1);
        if (line_cnt < 65535) line_cnt++;
        pos = sat_inc(pos);
      end
      put_tok(TK_EOF, line_cnt, 0, pos, 0);
      scanner_reset();
    end
    if (byte_toks.size() > 0) byte_toks[byte_toks.size()-1].last = 1'b1;
    foreach (byte_toks[i]) tokens_due = {tokens_due, byte_toks[i]};
  endtask

  // watch both channels
  always @(posedge clk) begin
    sttk_pkg::rec_t want, got;
    if (rst) begin
      scanner_reset();
      tokens_due.delete();
      errors <= 0;
      bytes_seen <= 0;
      tokens_seen <= 0;
      tokens_pending <= 0;
    end else begin
      if (tok_valid && tok_ready) begin
        got = '{token_kind, line_no, column_no, byte_offset, token_len, final_of_run};
        tokens_seen <= tokens_seen + 1;
        if (tokens_due.size() == 0) begin
          if (errors < 10)
            $display("unexpected token: kind %0d line %0d col %0d off %0d len %0d",
                     got.kind, got.line, got.col, got.off, got.len);
          errors <= errors + 1;
        end else begin
          want = tokens_due.pop_front();
          if (got !== want) begin
            if (errors < 10)
              $display({"token mismatch: exp kind %0d line %0d col %0d off %0d len %0d",
                        " fin %0d, got kind %0d line %0d col %0d off %0d len %0d fin %0d"},
                       want.kind, want.line, want.col, want.off, want.len, want.last,
                       got.kind, got.line, got.col, got.off, got.len, got.last);
            errors <= errors + 1;
          end
        end
      end
      if (src_valid && src_ready) begin
        bytes_seen <= bytes_seen + 1;
        tokenize_byte(ch, end_of_source);
      end
      tokens_pending <= tokens_due.size();
    end
  end
endmodule
`default_nettype wire

@@ tb/source_tokenizer_tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module source_tokenizer_tb;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BYTES = 360;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        src_valid = 1'b0;
  logic [7:0]  ch = 8'h00;
  logic        end_of_source = 1'b0;
  logic        tok_ready = 1'b0;
  wire         src_ready, tok_valid, final_of_run;
  wire  [5:0]  token_kind;
  wire  [15:0] line_no, column_no, byte_offset, token_len;
  int          errors, tokens_pending, bytes_seen, tokens_seen;
  int          cycles = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          sources_sent = 0;
  logic [7:0]  text[$];

  source_tokenizer dut (.*);

  source_tokenizer_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure and run limit
  always @(posedge clk) begin
    tok_ready <= ($urandom_range(99) >= stall_pct);
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] b);
    text = {text, b};
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // one source transaction per byte, end flag on the last one
  task automatic send_text();
    for (int i = 0; i < text.size(); i++) begin
      if ($urandom_range(99) < idle_pct) begin
        src_valid <= 1'b0;
        do @(posedge clk); while ($urandom_range(99) < idle_pct);
      end
      src_valid <= 1'b1;
      ch <= text[i];
      end_of_source <= (i == text.size() - 1);
      @(posedge clk);
      while (!src_ready) @(posedge clk);
    end
    src_valid <= 1'b0;
    text.delete();
    sources_sent++;
  endtask

  task automatic drain();
    do @(negedge clk); while (tokens_pending != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic random_fragment();
    string ops, tail, lone;
    int n;
    ops = "=+-*/%:.!<>|&";
    tail = "=>:.|&/";
    lone = ",{}()[]~$@;";
    case ($urandom_range(13))
      0, 1: begin
        add_byte($urandom_range(1) ? 8'("a" + $urandom_range(25)) : "_");
        repeat ($urandom_range(5)) add_byte(8'("A" + $urandom_range(25)));
        if ($urandom_range(1)) add_byte(8'("0" + $urandom_range(9)));
      end
      2: repeat ($urandom_range(1, 4)) add_byte(8'("0" + $urandom_range(9)));
      3: begin
        add_byte(8'("0" + $urandom_range(9)));
        add_byte(".");
        case ($urandom_range(3))
          0: add_byte(".");
          1: add_byte("/");
          2: add_byte("q");
          default: repeat ($urandom_range(1, 3)) add_byte(8'("0" + $urandom_range(9)));
        endcase
      end
      4: begin
        add_byte($urandom_range(1) ? "\"" : "'");
        n = $urandom_range(6);
        repeat (n) begin
          case ($urandom_range(9))
            0: add_byte("\\");
            1: add_byte("n");
            2: add_byte("\n");
            3: add_byte("\"");
            4: add_byte("'");
            default: add_byte(8'(8'h20 + $urandom_range(94)));
          endcase
        end
        if ($urandom_range(3) != 0) add_byte($urandom_range(1) ? "\"" : "'");
      end
      5, 6: begin
        add_byte(ops[$urandom_range(ops.len() - 1)]);
        if ($urandom_range(1)) add_byte(tail[$urandom_range(tail.len() - 1)]);
      end
      7: add_byte(lone[$urandom_range(lone.len() - 1)]);
      8, 9: case ($urandom_range(3))
        0: add_byte(8'h09);
        1: add_byte(8'h0D);
        2: add_byte(8'h00);
        default: add_byte(" ");
      endcase
      10: add_byte("\n");
      11: begin
        push_str("//");
        repeat ($urandom_range(4)) add_byte(8'($urandom_range(255)));
        if ($urandom_range(3) != 0) add_byte("\n");
      end
      default: add_byte(8'($urandom_range(255)));
    endcase
  endtask

  initial begin
    int sent;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: names, numbers, floats, bad floats, range after digits
    push_str("a_Z9 12.5 3./x 7..\n");
    send_text();
    // strings broken by backslash-n and newline, other escapes, chars
    push_str("\"a\\qb\" 'c' \"x\\ny \"z\n");
    send_text();
    // high byte run swallowing quotes, comment, semicolon, open operator
    add_byte(8'hFF);
    push_str("\"+ //c\n;");
    add_byte(8'h00);
    add_byte(8'h09);
    push_str("-");
    send_text();
    // source ending inside a string
    push_str("'ab");
    send_text();
    drain();

    // random sources over four pacing phases
    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1 || ph == 3) ? (ph == 3 ? 8 : 77) : 0;
      stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 8 : 77) : 0;
      while (sent < RANDOM_BYTES * (ph + 1) / 4) begin
        repeat ($urandom_range(3, 12)) random_fragment();
        sent += text.size();
        send_text();
      end
      // pause until every token has come out
      drain();
    end
    idle_pct = 0;
    stall_pct = 0;
    drain();

    $display("tokenized %0d bytes in %0d sources into %0d tokens under four pacing mixes",
             bytes_seen, sources_sent, tokens_seen);
    if (errors == 0 && tokens_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
sv/sttk_pkg.sv
sv/sttk_lexer.sv
sv/sttk_outbuf.sv
sv/source_tokenizer.sv
tb/source_tokenizer_checker.sv
tb/source_tokenizer_tb.sv
